### hw/rtl/sols_pkg.sv
`timescale 1ns / 1ps
package sols_pkg;

    localparam int CMP_W  = 9;
    localparam int KEY_W  = 32;
    localparam int ILEN_W = 9;
    localparam int POL_W  = 2;

    localparam logic [POL_W-1:0] POL_SEQ   = 2'd0;
    localparam logic [POL_W-1:0] POL_MTF   = 2'd1;
    localparam logic [POL_W-1:0] POL_TRANS = 2'd2;
    localparam logic [POL_W-1:0] POL_COUNT = 2'd3;

    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_INIT_LEN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RELOAD,
        S_SCAN,
        S_SCAN_CHK,
        S_CS,
        S_CS_CHK,
        S_MVD,
        S_MVD_WR,
        S_MVU,
        S_MVU_WR,
        S_PUT,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RL_WRITE,
        OP_RL_DONE,
        OP_READ,
        OP_READ_PREV,
        OP_READ_NEXT,
        OP_PTR_INC,
        OP_HIT,
        OP_MISS,
        OP_CS_FOUND,
        OP_WR_DOWN,
        OP_WR_UP,
        OP_PUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic             func;
        logic [POL_W-1:0] policy;
        logic             ptr_eq_len;
        logic             ptr_eq_pos;
        logic             ptr_eq_dst;
        logic             ptr_eq_n;
        logic             ptr_zero;
        logic             ptr_le_pos;
        logic             key_match;
        logic             cnt_le;
        logic             full;
    } dp_status_t;

endpackage

### hw/rtl/sols_ctrl.sv
`timescale 1ns / 1ps
module sols_ctrl
    import sols_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = st.func ? S_RELOAD : S_SCAN;
            end
            S_RELOAD:
            begin
                if (st.ptr_eq_n)
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (!st.ptr_eq_len)
                begin
                    state_next = S_SCAN_CHK;
                end
                else if (st.full)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    unique case (st.policy)
                        POL_SEQ:   state_next = S_PUT;
                        POL_COUNT: state_next = S_CS;
                        default:   state_next = S_MVD;
                    endcase
                end
            end
            S_SCAN_CHK:
            begin
                if (!st.key_match)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    unique case (st.policy)
                        POL_SEQ:   state_next = S_RESP;
                        POL_MTF:   state_next = S_MVD;
                        POL_TRANS: state_next = st.ptr_zero ? S_RESP : S_MVD;
                        default:   state_next = S_CS;
                    endcase
                end
            end
            S_CS:
            begin
                if (st.ptr_eq_len)
                begin
                    state_next = st.ptr_le_pos ? S_MVD : S_MVU;
                end
                else if (!st.ptr_eq_pos)
                begin
                    state_next = S_CS_CHK;
                end
            end
            S_CS_CHK:
            begin
                if (st.cnt_le)
                begin
                    state_next = st.ptr_le_pos ? S_MVD : S_MVU;
                end
                else
                begin
                    state_next = S_CS;
                end
            end
            S_MVD:
            begin
                state_next = st.ptr_eq_dst ? S_PUT : S_MVD_WR;
            end
            S_MVD_WR:
            begin
                state_next = S_MVD;
            end
            S_MVU:
            begin
                state_next = st.ptr_eq_dst ? S_PUT : S_MVU_WR;
            end
            S_MVU_WR:
            begin
                state_next = S_MVU;
            end
            S_PUT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_RESP);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_RELOAD:
            begin
                cmd.op = st.ptr_eq_n ? OP_RL_DONE : OP_RL_WRITE;
            end
            S_SCAN:
            begin
                cmd.op = st.ptr_eq_len ? OP_MISS : OP_READ;
            end
            S_SCAN_CHK:
            begin
                cmd.op = st.key_match ? OP_HIT : OP_PTR_INC;
            end
            S_CS:
            begin
                if (st.ptr_eq_len)
                begin
                    cmd.op = OP_CS_FOUND;
                end
                else if (st.ptr_eq_pos)
                begin
                    cmd.op = OP_PTR_INC;
                end
                else
                begin
                    cmd.op = OP_READ;
                end
            end
            S_CS_CHK:
            begin
                cmd.op = st.cnt_le ? OP_CS_FOUND : OP_PTR_INC;
            end
            S_MVD:
            begin
                if (!st.ptr_eq_dst)
                begin
                    cmd.op = OP_READ_PREV;
                end
            end
            S_MVD_WR:
            begin
                cmd.op = OP_WR_DOWN;
            end
            S_MVU:
            begin
                if (!st.ptr_eq_dst)
                begin
                    cmd.op = OP_READ_NEXT;
                end
            end
            S_MVU_WR:
            begin
                cmd.op = OP_WR_UP;
            end
            S_PUT:
            begin
                cmd.op = OP_PUT;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

### hw/rtl/sols_dp.sv
`timescale 1ns / 1ps
module sols_dp
    import sols_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ILEN_W-1:0] cfg_data,
    input  logic              func,
    input  logic [KEY_W-1:0]  key,
    input  ctl_cmd_t          cmd,
    output dp_status_t        st,
    output logic [CMP_W-1:0]  comparisons,
    output logic              found,
    output logic              dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    logic [KEY_W-1:0]      mem_key [CAPACITY];
    logic [COUNT_BITS-1:0] mem_cnt [CAPACITY];

    logic [POL_W-1:0]  policy_reg;
    logic [ILEN_W-1:0] init_len_reg;
    logic [LW-1:0]     len_reg,   len_next;
    logic [LW-1:0]     ptr_reg,   ptr_next;
    logic [LW-1:0]     pos_reg,   pos_next;
    logic [LW-1:0]     dst_reg,   dst_next;
    logic [LW-1:0]     cmp_reg,   cmp_next;
    logic              found_reg, found_next;
    logic              drop_reg,  drop_next;
    logic              func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]      rd_key_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;

    logic [31:0]           il32;
    logic [31:0]           n32;
    logic [LW-1:0]         reload_n;
    logic [LW-1:0]         rd_ptr;
    logic                  rd_en;
    logic                  wr_en;
    logic [LW-1:0]         wr_ptr;
    logic [KEY_W-1:0]      wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [LW+CMP_W-1:0]   cmp_ext;

    always_comb
    begin
        il32     = {{(32-ILEN_W){1'b0}}, init_len_reg};
        n32      = (il32 > 32'(CAPACITY)) ? 32'(CAPACITY) : il32;
        reload_n = n32[LW-1:0];
        cnt_inc  = (&rd_cnt_reg) ? rd_cnt_reg : rd_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= POL_SEQ;
            init_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_POLICY)
            begin
                policy_reg <= cfg_data[POL_W-1:0];
            end
            else
            begin
                init_len_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        dst_next   = dst_reg;
        cmp_next   = cmp_reg;
        found_next = found_reg;
        drop_next  = drop_reg;
        cnt_next   = cnt_reg;
        rd_en      = 1'b0;
        rd_ptr     = ptr_reg;
        wr_en      = 1'b0;
        wr_ptr     = ptr_reg;
        wr_key     = rd_key_reg;
        wr_cnt     = rd_cnt_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                ptr_next   = '0;
                cmp_next   = '0;
                found_next = 1'b0;
                drop_next  = 1'b0;
            end
            OP_RL_WRITE:
            begin
                wr_en    = 1'b1;
                wr_key   = KEY_W'(ptr_reg) + 1'b1;
                wr_cnt   = '0;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_RL_DONE:
            begin
                len_next = reload_n;
            end
            OP_READ:
            begin
                rd_en = 1'b1;
            end
            OP_READ_PREV:
            begin
                rd_en  = 1'b1;
                rd_ptr = ptr_reg - 1'b1;
            end
            OP_READ_NEXT:
            begin
                rd_en  = 1'b1;
                rd_ptr = ptr_reg + 1'b1;
            end
            OP_PTR_INC:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            OP_HIT:
            begin
                pos_next   = ptr_reg;
                found_next = 1'b1;
                cmp_next   = ptr_reg + 1'b1;
                cnt_next   = (policy_reg == POL_COUNT) ? cnt_inc : rd_cnt_reg;
                dst_next   = (policy_reg == POL_TRANS) ? ptr_reg - 1'b1 : '0;
                if (policy_reg == POL_COUNT)
                begin
                    ptr_next = '0;
                end
            end
            OP_MISS:
            begin
                pos_next  = len_reg;
                cmp_next  = len_reg;
                drop_next = (len_reg == CAP_L);
                cnt_next  = (policy_reg == POL_COUNT) ? COUNT_BITS'(1) : '0;
                dst_next  = (policy_reg == POL_SEQ) ? len_reg : '0;
                ptr_next  = (policy_reg == POL_COUNT) ? '0 : len_reg;
            end
            OP_CS_FOUND:
            begin
                dst_next = (ptr_reg <= pos_reg) ? ptr_reg : ptr_reg - 1'b1;
                ptr_next = pos_reg;
            end
            OP_WR_DOWN:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg - 1'b1;
            end
            OP_WR_UP:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_PUT:
            begin
                wr_en  = 1'b1;
                wr_ptr = dst_reg;
                wr_key = key_reg;
                wr_cnt = cnt_reg;
                if (!found_reg)
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            dst_reg   <= '0;
            cmp_reg   <= '0;
            found_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            pos_reg   <= pos_next;
            dst_reg   <= dst_next;
            cmp_reg   <= cmp_next;
            found_reg <= found_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.op == OP_LOAD)
        begin
            func_reg <= func;
            key_reg  <= key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[wr_ptr[AW-1:0]] <= wr_key;
            mem_cnt[wr_ptr[AW-1:0]] <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem_key[rd_ptr[AW-1:0]];
            rd_cnt_reg <= mem_cnt[rd_ptr[AW-1:0]];
        end
    end

    always_comb
    begin
        st.func       = func_reg;
        st.policy     = policy_reg;
        st.ptr_eq_len = (ptr_reg == len_reg);
        st.ptr_eq_pos = (ptr_reg == pos_reg);
        st.ptr_eq_dst = (ptr_reg == dst_reg);
        st.ptr_eq_n   = (ptr_reg == reload_n);
        st.ptr_zero   = (ptr_reg == '0);
        st.ptr_le_pos = (ptr_reg <= pos_reg);
        st.key_match  = (rd_key_reg == key_reg);
        st.cnt_le     = (rd_cnt_reg <= cnt_reg);
        st.full       = (len_reg == CAP_L);
        cmp_ext       = {{CMP_W{1'b0}}, cmp_reg};
        comparisons   = cmp_ext[CMP_W-1:0];
        found         = found_reg;
        dropped       = drop_reg;
    end

endmodule

### hw/rtl/self_organizing_list_search_unit.sv
`timescale 1ns / 1ps
// channel  direction  handshake           word
// cfg      in         cfg_write           cfg_index, cfg_data
// in       in         in_valid/in_stall   func, key
// out      out        out_valid/out_stall comparisons, found, dropped
//
// One word at a time; in_stall is high from accept until the result is taken.
// Lookup: dispatch, then a registered read and a check per scanned entry, a miss
// step on a miss, then a read and a write per moved entry, the last check and the
// put. Count policy adds a read and compare per entry and a skip of the hit.
// Result holds until taken. Reload writes min(initial_length, CAPACITY) entries.
// Reset clears policy, initial_length and list length; list memory is not cleared.
module self_organizing_list_search_unit
    import sols_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ILEN_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [KEY_W-1:0]  key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CMP_W-1:0]  comparisons,
    output logic              found,
    output logic              dropped
);

    ctl_cmd_t   cmd;
    dp_status_t st;

    sols_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    sols_dp #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .key         (key),
        .cmd         (cmd),
        .st          (st),
        .comparisons (comparisons),
        .found       (found),
        .dropped     (dropped)
    );

endmodule

### tb/self_organizing_list_search_unit_tb.sv
`timescale 1ns / 1ps
module self_organizing_list_search_unit_tb;
    import sols_pkg::*;

    localparam int CAP    = 256;
    localparam int CNT_W  = 4;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    typedef struct packed {
        logic [CMP_W-1:0] comparisons;
        logic             found;
        logic             dropped;
    } lookup_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [ILEN_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    logic [KEY_W-1:0]  key;
    logic              out_valid;
    logic              out_stall;
    logic [CMP_W-1:0]  comparisons;
    logic              found;
    logic              dropped;

    self_organizing_list_search_unit #(.CAPACITY(CAP), .COUNT_BITS(CNT_W)) dut (.*);

    // shadow list
    logic [KEY_W-1:0] list_keys [CAP];
    int unsigned      list_cnts [CAP];
    int               list_len;
    logic [POL_W-1:0] cur_policy;
    int               cur_init_len;

    lookup_result_t   expected_q [$];
    int               errors;
    int               idle_pct;
    int               stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("self_organizing_list_search_unit_tb: errors");
        $finish;
    end

    function automatic void list_remove(int p);
        for (int i = p; i < list_len - 1; i++)
        begin
            list_keys[i] = list_keys[i + 1];
            list_cnts[i] = list_cnts[i + 1];
        end
        list_len--;
    endfunction

    function automatic void list_insert(int p, logic [KEY_W-1:0] k, int unsigned c);
        for (int i = list_len; i > p; i--)
        begin
            list_keys[i] = list_keys[i - 1];
            list_cnts[i] = list_cnts[i - 1];
        end
        list_keys[p] = k;
        list_cnts[p] = c;
        list_len++;
    endfunction

    function automatic int first_not_above(int unsigned c);
        int q;
        q = 0;
        while (q < list_len && list_cnts[q] > c)
            q++;
        return q;
    endfunction

    function automatic lookup_result_t search_and_reorder(logic f, logic [KEY_W-1:0] k);
        lookup_result_t r;
        int p;
        int unsigned c;
        logic [KEY_W-1:0] tk;
        r = '0;
        if (f)
        begin
            list_len = (cur_init_len > CAP) ? CAP : cur_init_len;
            for (int i = 0; i < list_len; i++)
            begin
                list_keys[i] = i + 1;
                list_cnts[i] = 0;
            end
            return r;
        end
        p = 0;
        while (p < list_len && list_keys[p] != k)
            p++;
        if (p < list_len)
        begin
            r.found = 1'b1;
            r.comparisons = CMP_W'(p + 1);
            c = list_cnts[p];
            case (cur_policy)
                POL_MTF:
                begin
                    list_remove(p);
                    list_insert(0, k, c);
                end
                POL_TRANS:
                    if (p > 0)
                    begin
                        tk = list_keys[p - 1];
                        list_keys[p - 1] = list_keys[p];
                        list_keys[p] = tk;
                        list_cnts[p] = list_cnts[p - 1];
                        list_cnts[p - 1] = c;
                    end
                POL_COUNT:
                begin
                    if (c < CNT_MAX)
                        c++;
                    list_remove(p);
                    list_insert(first_not_above(c), k, c);
                end
                default: ;
            endcase
        end
        else
        begin
            r.comparisons = CMP_W'(list_len);
            if (list_len >= CAP)
                r.dropped = 1'b1;
            else if (cur_policy == POL_SEQ)
                list_insert(list_len, k, 0);
            else if (cur_policy == POL_COUNT)
                list_insert(first_not_above(1), k, 1);
            else
                list_insert(0, k, 0);
        end
        return r;
    endfunction

    always @(negedge clk)
        out_stall = rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        lookup_result_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: comparisons %0d found %0d dropped %0d",
                       comparisons, found, dropped);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (comparisons !== e.comparisons)
                begin
                    $error("comparisons: expected %0d actual %0d", e.comparisons, comparisons);
                    errors++;
                end
                if (found !== e.found)
                begin
                    $error("found: expected %0d actual %0d", e.found, found);
                    errors++;
                end
                if (dropped !== e.dropped)
                begin
                    $error("dropped: expected %0d actual %0d", e.dropped, dropped);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic f, logic [KEY_W-1:0] k);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        key = k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(search_and_reorder(f, k));
    endtask

    task automatic lookup(logic [KEY_W-1:0] k);
        send_word(1'b0, k);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        drain();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = ILEN_W'(value);
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == REG_POLICY)
            cur_policy = POL_W'(value);
        else
            cur_init_len = value;
    endtask

    task automatic reload(int n);
        write_reg(REG_INIT_LEN, n);
        send_word(1'b1, $urandom);
    endtask

    task automatic test_empty_and_extremes();
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        lookup(32'h8000_0000);
        lookup(32'h7FFF_FFFF);
        lookup(32'hFFFF_FFFF);
        reload(0);
        lookup(32'h0000_0005);
    endtask

    task automatic test_full_list();
        reload(300);
        lookup(32'hDEAD_BEEF);
        lookup(32'd256);
        lookup(32'd1);
        reload(256);
        write_reg(REG_POLICY, POL_COUNT);
        lookup(32'h8000_0001);
    endtask

    task automatic test_policies();
        reload(4);
        write_reg(REG_POLICY, POL_MTF);
        lookup(32'd3);
        lookup(32'hFFFF_FFF0);
        write_reg(REG_POLICY, POL_TRANS);
        lookup(32'd4);
        lookup(32'd1);
        lookup(32'h1234_5678);
    endtask

    task automatic test_count_saturation();
        write_reg(REG_POLICY, POL_COUNT);
        reload(3);
        repeat (18) lookup(32'd2);
        lookup(32'd3);
        lookup(32'h0000_0077);
        lookup(32'd3);
    endtask

    task automatic test_random();
        int modes_idle [4] = '{0, 83, 0, 8};
        int modes_stall [4] = '{0, 0, 83, 8};
        logic [KEY_W-1:0] k;
        for (int m = 0; m < 4; m++)
        begin
            idle_pct = modes_idle[m];
            stall_pct = modes_stall[m];
            for (int pol = 0; pol < 4; pol++)
            begin
                write_reg(REG_POLICY, pol);
                reload($urandom_range(24));
                for (int i = 0; i < 58; i++)
                begin
                    if ($urandom_range(29) == 0)
                    begin
                        if (list_len > 60)
                            reload($urandom_range(12));
                        else
                            send_word(1'b1, $urandom);
                    end
                    else if ($urandom_range(9) == 0)
                        lookup($urandom);
                    else if ($urandom_range(9) == 0)
                        lookup(-$urandom_range(6));
                    else if (list_len > 0 && $urandom_range(1))
                        lookup(list_keys[$urandom_range(list_len - 1)]);
                    else
                    begin
                        k = $urandom_range(40);
                        lookup(k);
                    end
                    if (i == 29 && $urandom_range(1))
                        write_reg(REG_POLICY, $urandom_range(3));
                end
                // keep the mode's idle percentage for the next policy
                idle_pct = (m == 0) ? 0 : modes_idle[m];
            end
        end
        idle_pct = 0;
        stall_pct = 0;
        write_reg(REG_INIT_LEN, 511);
        send_word(1'b1, 32'h0);
        lookup(32'hAAAA_5555);
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        list_len = 0;
        cur_policy = POL_SEQ;
        cur_init_len = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        key = '0;
        out_stall = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_and_extremes();
        test_policies();
        test_full_list();
        test_count_saturation();
        test_random();
        drain();
        if (errors == 0)
            $display("self_organizing_list_search_unit_tb: clean");
        else
            $display("self_organizing_list_search_unit_tb: errors");
        $finish;
    end

endmodule
